@@ rtl/selfp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selfp_pkg: shared types and constants for the sorted event list
// Command and status codes, sequencer states and the result record.
// ---------------------------------------------------------------------------
package selfp_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 256;
  localparam int unsigned KEY_WIDTH_DEF  = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned MODE_W         = 2;

  localparam logic [MODE_W-1:0] MODE_POS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DUR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REL = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT      = 3'd0,
    REQ_CLEAR       = 3'd1,
    REQ_REWIND      = 3'd2,
    REQ_READ        = 3'd3,
    REQ_POP         = 3'd4,
    REQ_REMOVE_PREV = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOCUR   = 2'd2,
    STAT_BADREM  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_INS_BEFORE,
    ST_INS_C,
    ST_APPEND,
    ST_SETN_RD,
    ST_SETN_WR,
    ST_SETP_RD,
    ST_SETP_WR,
    ST_UL_RD,
    ST_UL_DAT,
    ST_UL_FREE,
    ST_RP_DAT,
    ST_RD_DAT,
    ST_FIN
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [FIELD_W-1:0]  pos;
    logic [FIELD_W-1:0]  dur;
    logic [FIELD_W-1:0]  rel;
    logic [FIELD_W-1:0]  payload;
  } res_t;

endpackage

@@ rtl/selfp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selfp_if: command and result channels
// Valid/ready channels carrying one command or one result transaction.
// ---------------------------------------------------------------------------
interface selfp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] ev_pos;
  logic [31:0] ev_dur;
  logic [31:0] ev_release;
  logic [31:0] ev_payload;

  modport source (output valid, req_type, ev_pos, ev_dur, ev_release, ev_payload,
                  input ready);
  modport sink   (input valid, req_type, ev_pos, ev_dur, ev_release, ev_payload,
                  output ready);
endinterface

interface selfp_out_if #(
  parameter int unsigned CNT_W = 9
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [31:0]      out_pos;
  logic [31:0]      out_dur;
  logic [31:0]      out_release;
  logic [31:0]      out_payload;
  logic [CNT_W-1:0] list_count;

  modport source (output valid, status, out_pos, out_dur, out_release, out_payload,
                  list_count, input ready);
  modport sink   (input valid, status, out_pos, out_dur, out_release, out_payload,
                  list_count, output ready);
endinterface

@@ rtl/selfp_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selfp_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module selfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/selfp_out_reg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selfp_out_reg: result output register
// Hold one result transaction until the sink takes it.
// ---------------------------------------------------------------------------
module selfp_out_reg
  import selfp_pkg::*;
#(
  parameter int unsigned CNT_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_t             res_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic             free_o,
  selfp_out_if.source      res_o
);

  logic       valid_q;
  res_t       res_q;
  logic [CNT_W-1:0] cnt_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
      cnt_q <= cnt_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.status      = res_q.status;
  assign res_o.out_pos     = res_q.pos;
  assign res_o.out_dur     = res_q.dur;
  assign res_o.out_release = res_q.rel;
  assign res_o.out_payload = res_q.payload;
  assign res_o.list_count  = cnt_q;

endmodule

@@ rtl/sorted_event_list_with_free_pool_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_event_list_with_free_pool_unit: sorted event list over a slot pool
// Events live in a pool of slots, linked into one doubly linked list kept
// sorted by position, duration or release. A cursor walks the list.
// ---------------------------------------------------------------------------
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------
//  evt_i     | in  | valid/ready        | req_type, ev_pos/dur/release/payload
//  res_o     | out | valid/ready        | status, out_*, list_count
//  cfg_*_i   | in  | write enable only  | sort_mode (2 bits)
//
//  Insert walks the list one entry at a time, reading each entry and then
//  comparing its key, as the link and event memories each have a single
//  read port.
//  Reset: list empty, cursor null, sort_mode 0; no memory clearing pass,
//  unused slots are handed out from a fill counter.
//  One command at a time; a finished result waits in the output register
//  while the next command is taken, and a further result stalls there.
// ---------------------------------------------------------------------------
module sorted_event_list_with_free_pool_unit
  import selfp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  selfp_in_if.sink          evt_i,
  selfp_out_if.source       res_o
);

  localparam int unsigned LW   = $clog2(POOL_DEPTH + 1);  // link incl. null
  localparam int unsigned IW   = $clog2(POOL_DEPTH);      // slot index
  localparam int unsigned EV_W = 4 * FIELD_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
  localparam logic [LW-1:0] FULL_CNT  = LW'(POOL_DEPTH);

  // Sequencer and list registers
  state_e             state_q, state_d;
  logic [LW-1:0]      head_q, tail_q, cur_q, fh_q, fresh_q, cnt_q;
  logic [MODE_W-1:0]  mode_q;
  // Command and walk registers
  req_e               req_q;
  logic [FIELD_W-1:0] pos_q, dur_q, rel_q, pl_q;
  logic [LW-1:0]      s_q, c_q, pc_q, cn_q, x_q, v_q, p_q, n_q;
  res_t               res_q;
  res_t               res_init;

  // Memory ports
  logic               rd_en;
  logic [LW-1:0]      rd_link;
  logic               ev_we, lk_we;
  logic [LW-1:0]      lk_wlink;
  logic [2*LW-1:0]    lk_wdata;
  logic [2*LW-1:0]    lk_rdata;
  logic [EV_W-1:0]    ev_rdata;
  logic [LW-1:0]      rd_next, rd_prev;

  logic in_fire, out_free, out_load, less, append, ul;
  req_e req_in;

  function automatic logic live(input logic [LW-1:0] l);
    return l < NULL_LINK;
  endfunction

  // Pick the key field for the sort mode, sign extended to 64 bits
  function automatic logic [63:0] key_of(input logic [MODE_W-1:0] m,
                                         input logic [FIELD_W-1:0] p,
                                         input logic [FIELD_W-1:0] d,
                                         input logic [FIELD_W-1:0] r);
    logic [FIELD_W-1:0] k;
    k = (m == MODE_DUR) ? d : ((m == MODE_REL) ? r : p);
    return {{(64-FIELD_W){k[FIELD_W-1]}}, k};
  endfunction

  logic [63:0] new_key, cur_key;

  assign in_fire = evt_i.valid && evt_i.ready;
  assign req_in  = req_e'(evt_i.req_type);
  assign evt_i.ready = (state_q == ST_IDLE);
  assign rd_next = lk_rdata[2*LW-1:LW];
  assign rd_prev = lk_rdata[LW-1:0];
  assign ul      = (req_q == REQ_POP) || (req_q == REQ_REMOVE_PREV);

  assign new_key = key_of(mode_q, pos_q, dur_q, rel_q);
  assign cur_key = key_of(mode_q, ev_rdata[FIELD_W-1:0], ev_rdata[2*FIELD_W-1:FIELD_W],
                          ev_rdata[3*FIELD_W-1:2*FIELD_W]);
  // Strictly smaller: equal keys keep the new entry behind the old ones
  assign less    = $signed(new_key[KEY_WIDTH-1:0]) < $signed(cur_key[KEY_WIDTH-1:0]);
  // Unknown mode, and an all-ones duration in duration mode, go to the tail
  assign append  = (mode_q > MODE_REL) || ((mode_q == MODE_DUR) && (&dur_q));
  assign out_load = (state_q == ST_FIN) && out_free;

  // First result of an accepted command: echo for insert, refusals decided here
  always_comb begin
    res_init = '{status: STAT_OK, pos: '0, dur: '0, rel: '0, payload: '0};
    case (req_in)
      REQ_INSERT: begin
        res_init = '{status: (cnt_q == FULL_CNT) ? STAT_FULL : STAT_OK,
                     pos: evt_i.ev_pos, dur: evt_i.ev_dur,
                     rel: evt_i.ev_release, payload: evt_i.ev_payload};
      end
      REQ_READ, REQ_POP: begin
        if (!live(cur_q)) begin
          res_init.status = STAT_NOCUR;
        end
      end
      REQ_REMOVE_PREV: begin
        if (cnt_q == '0 || (live(cur_q) && cur_q == head_q)) begin
          res_init.status = STAT_BADREM;
        end
      end
      default: ;
    endcase
  end

  // Memories: events {payload, release, dur, pos}; links {next, prev}
  selfp_ram #(.WIDTH(EV_W), .DEPTH(POOL_DEPTH)) u_ev_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (s_q[IW-1:0]),
    .wdata_i ({pl_q, rel_q, dur_q, pos_q}),
    .re_i    (rd_en),
    .raddr_i (rd_link[IW-1:0]),
    .rdata_o (ev_rdata)
  );

  selfp_ram #(.WIDTH(2*LW), .DEPTH(POOL_DEPTH)) u_lk_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_wlink[IW-1:0]),
    .wdata_i (lk_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_link[IW-1:0]),
    .rdata_o (lk_rdata)
  );

  selfp_out_reg #(.CNT_W(LW)) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (res_q),
    .cnt_i  (cnt_q),
    .free_o (out_free),
    .res_o  (res_o)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_in)
            REQ_INSERT: state_d = (cnt_q == FULL_CNT) ? ST_FIN : ST_ALLOC;
            REQ_READ:   state_d = live(cur_q) ? ST_RD_DAT : ST_FIN;
            REQ_POP:    state_d = live(cur_q) ? ST_UL_DAT : ST_FIN;
            REQ_REMOVE_PREV: begin
              if (cnt_q == '0) begin
                state_d = ST_FIN;
              end else if (!live(cur_q)) begin
                state_d = live(tail_q) ? ST_UL_DAT : ST_FIN;
              end else if (cur_q == head_q) begin
                state_d = ST_FIN;
              end else begin
                state_d = ST_RP_DAT;
              end
            end
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_ALLOC: begin
        if (!live(head_q))  state_d = ST_FIN;
        else if (append)    state_d = ST_APPEND;
        else                state_d = ST_WALK_RD;
      end
      ST_WALK_RD:    state_d = ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (less)                state_d = ST_INS_BEFORE;
        else if (live(rd_next))  state_d = ST_WALK_RD;
        else                     state_d = ST_APPEND;
      end
      ST_INS_BEFORE: state_d = ST_INS_C;
      ST_INS_C:      state_d = live(pc_q) ? ST_SETN_RD : ST_FIN;
      ST_APPEND:     state_d = live(tail_q) ? ST_SETN_RD : ST_FIN;
      ST_SETN_RD:    state_d = ST_SETN_WR;
      ST_SETN_WR: begin
        if (!ul)             state_d = ST_FIN;
        else if (live(n_q))  state_d = ST_SETP_RD;
        else                 state_d = ST_UL_FREE;
      end
      ST_SETP_RD:    state_d = ST_SETP_WR;
      ST_SETP_WR:    state_d = ST_UL_FREE;
      ST_UL_RD:      state_d = ST_UL_DAT;
      ST_UL_DAT: begin
        if (live(rd_prev))       state_d = ST_SETN_RD;
        else if (live(rd_next))  state_d = ST_SETP_RD;
        else                     state_d = ST_UL_FREE;
      end
      ST_UL_FREE:    state_d = ST_FIN;
      ST_RP_DAT:     state_d = live(rd_prev) ? ST_UL_RD : ST_FIN;
      ST_RD_DAT:     state_d = ST_FIN;
      ST_FIN:        state_d = out_free ? ST_IDLE : ST_FIN;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    rd_en    = 1'b0;
    rd_link  = cur_q;
    ev_we    = 1'b0;
    lk_we    = 1'b0;
    lk_wlink = s_q;
    lk_wdata = {NULL_LINK, NULL_LINK};
    unique case (state_q)
      ST_IDLE: begin
        rd_en = in_fire;
        if (req_in == REQ_INSERT) begin
          rd_link = fh_q;
        end else if (req_in == REQ_REMOVE_PREV && !live(cur_q)) begin
          rd_link = tail_q;
        end
      end
      ST_ALLOC: begin
        ev_we = 1'b1;
        lk_we = !live(head_q);
      end
      ST_WALK_RD: begin
        rd_en   = 1'b1;
        rd_link = c_q;
      end
      ST_INS_BEFORE: begin
        lk_we    = 1'b1;
        lk_wdata = {c_q, pc_q};
      end
      ST_INS_C: begin
        lk_we    = 1'b1;
        lk_wlink = c_q;
        lk_wdata = {cn_q, s_q};
      end
      ST_APPEND: begin
        lk_we    = 1'b1;
        lk_wdata = {NULL_LINK, tail_q};
      end
      ST_SETN_RD, ST_SETP_RD: begin
        rd_en   = 1'b1;
        rd_link = x_q;
      end
      ST_SETN_WR: begin
        lk_we    = 1'b1;
        lk_wlink = x_q;
        lk_wdata = {v_q, rd_prev};
      end
      ST_SETP_WR: begin
        lk_we    = 1'b1;
        lk_wlink = x_q;
        lk_wdata = {rd_next, v_q};
      end
      ST_UL_RD: begin
        rd_en   = 1'b1;
        rd_link = s_q;
      end
      ST_UL_FREE: begin
        lk_we    = 1'b1;
        lk_wdata = {fh_q, NULL_LINK};
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= NULL_LINK;
      tail_q  <= NULL_LINK;
      cur_q   <= NULL_LINK;
      fh_q    <= NULL_LINK;
      fresh_q <= '0;
      cnt_q   <= '0;
      mode_q  <= MODE_POS;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (req_in)
              REQ_INSERT: begin
                // take a recycled slot first, otherwise a never used one
                if (cnt_q != FULL_CNT && !live(fh_q)) begin
                  fresh_q <= fresh_q + LW'(1);
                end
              end
              REQ_CLEAR: begin
                head_q  <= NULL_LINK;
                tail_q  <= NULL_LINK;
                cur_q   <= NULL_LINK;
                fh_q    <= NULL_LINK;
                fresh_q <= '0;
                cnt_q   <= '0;
              end
              REQ_REWIND: cur_q <= head_q;
              default: ;
            endcase
          end
        end
        ST_ALLOC: begin
          if (live(fh_q)) begin
            fh_q <= rd_next;
          end
          cnt_q <= cnt_q + LW'(1);
          if (!live(head_q)) begin
            head_q <= s_q;
            tail_q <= s_q;
            cur_q  <= s_q;
          end
        end
        ST_INS_C: begin
          if (!live(pc_q)) begin
            head_q <= s_q;
          end
        end
        ST_APPEND: begin
          tail_q <= s_q;
          if (!live(tail_q)) begin
            head_q <= s_q;
          end
        end
        ST_SETN_WR: begin
          if (ul && !live(n_q)) begin
            tail_q <= p_q;
          end
        end
        ST_UL_DAT: begin
          if (req_q == REQ_POP) begin
            cur_q <= rd_next;
          end
          if (!live(rd_prev)) begin
            head_q <= rd_next;
            if (!live(rd_next)) begin
              tail_q <= rd_prev;
            end
          end
        end
        ST_UL_FREE: begin
          fh_q  <= s_q;
          cnt_q <= cnt_q - LW'(1);
        end
        ST_RD_DAT: cur_q <= rd_next;
        default: ;
      endcase
    end
  end

  // Command, walk and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_q <= req_in;
          pos_q <= evt_i.ev_pos;
          dur_q <= evt_i.ev_dur;
          rel_q <= evt_i.ev_release;
          pl_q  <= evt_i.ev_payload;
          res_q <= res_init;
          case (req_in)
            REQ_INSERT:        s_q <= live(fh_q) ? fh_q : fresh_q;
            REQ_READ, REQ_POP: s_q <= cur_q;
            REQ_REMOVE_PREV:   s_q <= tail_q;
            default: ;
          endcase
        end
      end
      ST_ALLOC: c_q <= head_q;
      ST_WALK_CMP: begin
        if (less) begin
          pc_q <= rd_prev;
          cn_q <= rd_next;
        end else begin
          c_q  <= rd_next;
        end
      end
      ST_INS_C: begin
        x_q <= pc_q;
        v_q <= s_q;
      end
      ST_APPEND: begin
        x_q <= tail_q;
        v_q <= s_q;
      end
      ST_SETN_WR: begin
        // move on to the back link of the follower
        x_q <= n_q;
        v_q <= p_q;
      end
      ST_UL_DAT: begin
        res_q.pos     <= ev_rdata[FIELD_W-1:0];
        res_q.dur     <= ev_rdata[2*FIELD_W-1:FIELD_W];
        res_q.rel     <= ev_rdata[3*FIELD_W-1:2*FIELD_W];
        res_q.payload <= ev_rdata[4*FIELD_W-1:3*FIELD_W];
        p_q <= rd_prev;
        n_q <= rd_next;
        if (live(rd_prev)) begin
          x_q <= rd_prev;
          v_q <= rd_next;
        end else begin
          x_q <= rd_next;
          v_q <= rd_prev;
        end
      end
      ST_RP_DAT: begin
        s_q <= rd_prev;
        if (!live(rd_prev)) begin
          res_q.status <= STAT_BADREM;
        end
      end
      ST_RD_DAT: begin
        res_q.pos     <= ev_rdata[FIELD_W-1:0];
        res_q.dur     <= ev_rdata[2*FIELD_W-1:FIELD_W];
        res_q.rel     <= ev_rdata[3*FIELD_W-1:2*FIELD_W];
        res_q.payload <= ev_rdata[4*FIELD_W-1:3*FIELD_W];
      end
      default: ;
    endcase
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= FULL_CNT) && (fresh_q <= FULL_CNT))
    else $error("entry or fill count beyond pool depth");

  a_head_vs_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (live(head_q) == (cnt_q != '0)))
    else $error("head pointer disagrees with entry count");

  a_tail_vs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (live(head_q) == live(tail_q)))
    else $error("head and tail pointers disagree");

  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("accepted command did not start");

endmodule
